/* rtl/core/small_set_table_defines.svh */
// Assertion macros for the small set table RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SMALL_SET_TABLE_DEFINES_SVH
`define SMALL_SET_TABLE_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/sst_pkg.sv */
// Shared types and request codes for the small set table.
// No dependencies.
package sst_pkg;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_RSVD   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

/* rtl/core/sst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/small_set_table.sv */
// Small set table: bounded insertion-ordered set with add / remove / query.
// Depends on sst_pkg, sst_ram and small_set_table_defines.svh.
//
// Usage:
//   Slave channel (s_tvalid/s_tready): one request word per handshake,
//   s_tuser = request type (0 add, 1 remove, 2 query, 3 acts as query),
//   s_tdata = value. Master channel (m_tvalid/m_tready): one result word
//   per request with was_present, element_count, is_empty, add_dropped.
//   Entries sit in one RAM with registered read data and a request walks
//   them one per cycle. A remove that hits compacts the entries behind it
//   (read i+1, write i). Each request then passes ST_FIN, where an add
//   writes its value, and ST_OUT, which loads the output register.
//   Only one request is in flight; s_tready is high while the engine is idle.
//   The result sits in an output register, so a new request is taken while
//   an earlier result waits on m_tready. If a result finishes while the
//   output register is still full, the engine holds until it drains.
//   Reset clears the element count and the control state; the RAM is not
//   cleared since only entries below the count are ever used.
`include "small_set_table_defines.svh"

module small_set_table
	import sst_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type

	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] was_present, [CW:1] element_count, [CW+1] is_empty, [CW+2] add_dropped
	output logic [((($clog2(DEPTH + 1)) + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int SW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int TDW = ((CW + 3 + 7) / 8) * 8;

	state_t          state_q, state_d;
	req_t            req_q;
	logic [SW-1:0]   val_q;
	logic [AW-1:0]   pos_q;
	logic [CW-1:0]   count_q;
	logic            present_q;
	logic            dropped_q;
	logic            m_tvalid_q;
	logic [TDW-1:0]  m_tdata_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [SW-1:0]   ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [SW-1:0]   ram_rdata;

	logic [AW:0]     pos_nx;
	logic [AW:0]     rd_sum;
	logic            more;
	logic            hit;
	logic            accept;
	logic            out_free;
	logic            do_add;
	logic            room;
	logic [TDW-1:0]  res_data;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign pos_nx   = {1'b0, pos_q} + (AW + 1)'(1);
	assign more     = (CW + 1)'(pos_nx) < (CW + 1)'(count_q);
	assign hit      = (ram_rdata == val_q);
	assign room     = (CW + 1)'(count_q) < (CW + 1)'(DEPTH);
	assign do_add   = (req_q == REQ_ADD) && !present_q;

	// read runs one ahead of the compare while scanning, two ahead while shifting
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_sum = '0;
			ST_SHIFT: rd_sum = {1'b0, pos_q} + (AW + 1)'(2);
			default:  rd_sum = pos_nx;
		endcase
	end
	assign ram_raddr = rd_sum[AW-1:0];

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ram_rdata;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (count_q == '0) ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (req_q == REQ_REMOVE) ? ST_SHIFT : ST_FIN;
				end else if (!more) begin
					state_d = ST_FIN;
				end
			end
			ST_SHIFT: begin
				if (more) begin
					ram_we = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (do_add && room) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = val_q;
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SHIFT && !more) begin
				count_q <= count_q - CW'(1);
			end else if (state_q == ST_FIN && do_add && room) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_data         = '0;
		res_data[0]      = present_q;
		res_data[CW:1]   = count_q;
		res_data[CW + 1] = (count_q == '0);
		res_data[CW + 2] = dropped_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_t'(s_tuser);
			val_q     <= s_tdata[SW-1:0];
			pos_q     <= '0;
			present_q <= 1'b0;
			dropped_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				present_q <= 1'b1;
			end else if (more) begin
				pos_q <= pos_nx[AW-1:0];
			end
		end
		if (state_q == ST_SHIFT && more) begin
			pos_q <= pos_nx[AW-1:0];
		end
		if (state_q == ST_FIN) begin
			dropped_q <= do_add && !room;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= res_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	sst_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`SST_ASSERT_NOW(a_count_max, 1'b1, (CW + 1)'(count_q) <= (CW + 1)'(DEPTH))
	`SST_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE)
	`SST_ASSERT_NOW(a_we_state, ram_we, (state_q == ST_SHIFT) || (state_q == ST_FIN))
	`SST_ASSERT_NOW(a_shift_pos, state_q == ST_SHIFT, (CW + 1)'(pos_q) < (CW + 1)'(count_q))

endmodule

/* tb/small_set_table_tb.sv */
// Testbench for small_set_table: drives add/remove/query words with random gaps and
// back-pressure, predicts each result from an internal copy of the set and checks it.
// Depends on sst_pkg and the small_set_table RTL.
module small_set_table_tb;
	import sst_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int RW          = ((CW + 3 + 7) / 8) * 8;
	localparam int STALL_LEN   = 120;
	localparam int WDOG_LIMIT  = 1000;
	localparam int SETTLE      = 2 * DEPTH + 8;

	typedef struct packed {
		logic          add_dropped;
		logic          is_empty;
		logic [CW-1:0] element_count;
		logic          was_present;
	} set_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [31:0]   s_tdata = '0;
	logic [1:0]    s_tuser = REQ_QUERY;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [RW-1:0] m_tdata;

	// predicted set contents, kept in insertion order
	logic [31:0]   set_entries [DEPTH];
	int            set_count;
	set_result_t   pending_results [$];

	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            hold_seq = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	int            errors = 0;
	int            n_sent = 0;
	int            n_checked = 0;
	int            n_hits = 0;
	int            n_dropped = 0;
	int            n_emptied = 0;
	int            peak_count = 0;
	logic [31:0]   value_pool [64];
	int            pool_size = 8;

	small_set_table #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic set_result_t predict_set_op(req_t req, logic [31:0] v);
		set_result_t r;
		int pos;
		pos = DEPTH;
		for (int i = 0; i < set_count; i++) begin
			if (pos == DEPTH && set_entries[i] == v) begin
				pos = i;
			end
		end
		r = '0;
		r.was_present = (pos < DEPTH);
		if (req == REQ_ADD && pos == DEPTH) begin
			if (set_count < DEPTH) begin
				set_entries[set_count] = v;
				set_count++;
			end else begin
				r.add_dropped = 1'b1;
			end
		end else if (req == REQ_REMOVE && pos < DEPTH) begin
			for (int i = pos; i + 1 < set_count; i++) begin
				set_entries[i] = set_entries[i + 1];
			end
			set_count--;
			if (set_count == 0) begin
				n_emptied++;
			end
		end
		r.element_count = set_count[CW-1:0];
		r.is_empty      = (set_count == 0);
		if (r.was_present) begin
			n_hits++;
		end
		if (r.add_dropped) begin
			n_dropped++;
		end
		if (set_count > peak_count) begin
			peak_count = set_count;
		end
		return r;
	endfunction

	// one request word; valid stays high into the next call unless it idles first
	task automatic send_request(req_t req, logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pending_results.push_back(predict_set_op(req, v));
		n_sent++;
	endtask

	task automatic wait_results_drained();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic req_t pick_request();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45) begin
			return REQ_ADD;
		end else if (roll < 75) begin
			return REQ_REMOVE;
		end else if (roll < 95) begin
			return REQ_QUERY;
		end
		return REQ_RSVD;
	endfunction

	function automatic logic [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80) begin
			return value_pool[$urandom_range(pool_size - 1)];
		end else if (roll < 83) begin
			return 32'h0000_0000;
		end else if (roll < 86) begin
			return 32'hFFFF_FFFF;
		end
		return $urandom;
	endfunction

	task automatic refill_pool(int size);
		pool_size = size;
		foreach (value_pool[i]) begin
			value_pool[i] = $urandom;
		end
	endtask

	// empty set, extreme values, re-add, reserved type, remove of absent
	task automatic test_edge_values();
		send_request(REQ_QUERY,  32'h0000_0000);
		send_request(REQ_REMOVE, 32'hFFFF_FFFF);
		send_request(REQ_ADD,    32'h0000_0000);
		send_request(REQ_ADD,    32'hFFFF_FFFF);
		send_request(REQ_ADD,    32'h0000_0000);
		send_request(REQ_RSVD,   32'hFFFF_FFFF);
		send_request(REQ_REMOVE, 32'h0000_0000);
	endtask

	// fill to DEPTH, overflow add, re-add on full, remove from the middle
	task automatic test_full_set();
		for (int i = 1; i < DEPTH; i++) begin
			send_request(REQ_ADD, 32'h0101_0101 * i);
		end
		send_request(REQ_ADD,    32'h5A5A_5A5A);
		send_request(REQ_ADD,    32'h0707_0707);
		send_request(REQ_REMOVE, 32'h0808_0808);
	endtask

	task automatic test_random_traffic(int n, int size);
		refill_pool(size);
		for (int i = 0; i < n; i++) begin
			send_request(pick_request(), pick_value());
		end
	endtask

	// receiver holds off while requests keep coming, so the input backs up
	task automatic test_output_stall();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 12; i++) begin
			send_request(pick_request(), pick_value());
		end
		send_idle_pct = saved_idle;
	endtask

	task automatic test_drain_pause();
		test_random_traffic(10, 12);
		s_tvalid <= 1'b0;
		wait_results_drained();
		@(posedge clk);
		test_random_traffic(10, 12);
	endtask

	// receiver: random ready, or a long hold when the test asks for one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= STALL_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready  <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		set_result_t got;
		set_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = set_result_t'(m_tdata[CW+2:0]);
			if (pending_results.size() == 0) begin
				$error("result word 0x%0h with no request pending", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got.was_present !== want.was_present) begin
					$error("was_present: expected %0d, got %0d",
						want.was_present, got.was_present);
					errors++;
				end
				if (got.element_count !== want.element_count) begin
					$error("element_count: expected %0d, got %0d",
						want.element_count, got.element_count);
					errors++;
				end
				if (got.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d",
						want.is_empty, got.is_empty);
					errors++;
				end
				if (got.add_dropped !== want.add_dropped) begin
					$error("add_dropped: expected %0d, got %0d",
						want.add_dropped, got.add_dropped);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		set_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_full_set();

		send_idle_pct = 28;
		recv_idle_pct <= 74;
		test_random_traffic(60, 20);
		test_output_stall();
		test_random_traffic(60, 8);

		send_idle_pct = 74;
		recv_idle_pct <= 28;
		test_random_traffic(60, 24);
		test_drain_pause();
		test_random_traffic(40, 40);

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		test_random_traffic(60, 18);
		test_output_stall();
		test_random_traffic(40, 6);

		s_tvalid <= 1'b0;
		wait_results_drained();
		repeat (SETTLE) @(posedge clk);

		$display("sent %0d requests, checked %0d results: %0d hits, %0d full-set drops,",
			n_sent, n_checked, n_hits, n_dropped);
		$display("set drained to empty %0d times, peak occupancy %0d of %0d",
			n_emptied, peak_count, DEPTH);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
